[design/tlzw_pkg.sv]
package tlzw_pkg;

    localparam int DICT_ENTRIES_DEF  = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int STACK_DEPTH       = 4096;
    localparam int STACK_AW          = 12;

    localparam logic [11:0] CLEAR_CODE = 12'd256;
    localparam logic [11:0] END_CODE   = 12'd257;
    localparam logic [11:0] FIRST_FREE = 12'd258;

    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_PULL    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // One classified command handed from the front to the back.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] in_byte;
        logic       eos;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       accepted;
        logic       done_res;
        logic       bad_code;
    } res_t;

endpackage

[design/tiff_lzw_decoder_unit.sv]
// TIFF LZW decoder (early change, 9 to 12 bit codes). Each input transfer
// carries a command: push a compressed byte, pull one decoded byte, or
// restart for a new strip. Every command yields exactly one result transfer
// with the pulled byte and status flags. The decoder core takes a push or an
// empty pull through S_DEC, a pull that leaves bytes on the stack through
// S_POP, and a pull that empties the stack through S_POP and then S_DEC to
// look for the next code. Decoding a code adds S_LOOK and S_FIRST for the
// first-byte lookups and the new table entry, then walks the string onto the
// stack in S_WALK with a read and a push per byte taken from the table, a
// cost set by the single registered read port of the table, plus a push for
// the final literal byte. The command queue registers each command before
// the core takes it, and the core holds in S_RES while the last result waits.
// A two-entry command queue lets the input side keep running while the
// decoder core works or the result waits.
module tiff_lzw_decoder_unit #(
    parameter int DICT_ENTRIES  = tlzw_pkg::DICT_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = tlzw_pkg::MAX_CODE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // cmd[1:0], in_byte[9:2], end_of_stream[10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // out_byte[7:0], out_valid, accepted, done_res, bad_code
);

    logic           q_valid, q_ready;
    tlzw_pkg::cmd_t q_data;

    tlzw_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .s_tdata(s_tdata[10:0]), .q_valid, .q_ready, .q_data
    );

    tlzw_back #(.DICT_ENTRIES(DICT_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data, .m_tvalid, .m_tready, .m_tdata
    );

endmodule

[design/tlzw_front.sv]
module tlzw_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [10:0]         s_tdata,
    output logic                q_valid,
    input  logic                q_ready,
    output tlzw_pkg::cmd_t      q_data
);

    // Two-entry queue decoupling the input channel from the decoder core.
    tlzw_pkg::cmd_t mem_reg [2];
    logic           wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push, pop;
    tlzw_pkg::cmd_t in_c;

    assign in_c.cmd     = s_tdata[1:0];
    assign in_c.in_byte = s_tdata[9:2];
    assign in_c.eos     = s_tdata[10];

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rp_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_c;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[design/tlzw_back.sv]
module tlzw_back #(
    parameter int DICT_ENTRIES  = tlzw_pkg::DICT_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = tlzw_pkg::MAX_CODE_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  tlzw_pkg::cmd_t q_data,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata
);

    localparam int DW = $clog2(DICT_ENTRIES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_FIRST = 3'd4;
    localparam logic [2:0] S_RES   = 3'd5;
    localparam logic [2:0] S_POP   = 3'd6;

    logic [11:0] pfx_mem [DICT_ENTRIES];
    logic [7:0]  sfx_mem [DICT_ENTRIES];
    logic [7:0]  fst_mem [DICT_ENTRIES];
    logic [7:0]  stk_mem [tlzw_pkg::STACK_DEPTH];

    logic [2:0]  state_reg;
    logic [12:0] next_free_reg;
    logic [11:0] prev_code_reg;
    logic        prev_valid_reg;
    logic [18:0] buf_reg;
    logic [4:0]  bcnt_reg;
    logic [12:0] scnt_reg;
    logic        fin_reg;
    logic [11:0] code_reg, walk_reg;
    logic        kwk_reg;
    logic        bad_reg, acc_reg, ov_reg;
    logic [7:0]  ob_reg;
    logic [11:0] rd_pfx_reg;
    logic [7:0]  rd_sfx_reg, rd_fst_reg, rd_stk_reg;
    logic [7:0]  rd_fst_prev_reg;
    logic        rd_valid_reg;
    logic        out_full_reg;
    tlzw_pkg::res_t res_reg;

    logic [3:0]  width;
    logic [11:0] cand;
    logic [4:0]  rem;
    logic [18:0] mask;
    logic [DW:0] nf_dw;

    always_comb begin
        width = 4'd12;
        if (next_free_reg < 13'd2047) width = 4'd11;
        if (next_free_reg < 13'd1023) width = 4'd10;
        if (next_free_reg < 13'd511)  width = 4'd9;
        if (width > 4'(MAX_CODE_BITS)) width = 4'(MAX_CODE_BITS);
        rem  = bcnt_reg - {1'b0, width};
        cand = 12'((buf_reg >> rem) & ((19'd1 << width) - 19'd1));
        mask = (19'd1 << rem) - 19'd1;
        nf_dw = (DW + 1)'(next_free_reg);
    end

    assign q_ready  = (state_reg == S_IDLE);
    assign m_tvalid = out_full_reg;
    assign m_tdata  = {4'd0, res_reg.bad_code, res_reg.done_res, res_reg.accepted,
                       res_reg.out_valid, res_reg.out_byte};

    // Registered dictionary and stack reads. The first bytes of the new code
    // and of the previous code are captured while the code is classified.
    always_ff @(posedge aclk) begin
        rd_pfx_reg <= pfx_mem[walk_reg[DW-1:0]];
        rd_sfx_reg <= sfx_mem[walk_reg[DW-1:0]];
        if (state_reg == S_DEC) begin
            rd_fst_reg      <= fst_mem[cand[DW-1:0]];
            rd_fst_prev_reg <= fst_mem[prev_code_reg[DW-1:0]];
        end
        rd_stk_reg <= stk_mem[scnt_reg[tlzw_pkg::STACK_AW-1:0] - 12'd1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            next_free_reg  <= 13'(tlzw_pkg::FIRST_FREE);
            prev_code_reg  <= '0;
            prev_valid_reg <= 1'b0;
            buf_reg        <= '0;
            bcnt_reg       <= '0;
            scnt_reg       <= '0;
            fin_reg        <= 1'b0;
            out_full_reg   <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end else begin
            if (out_full_reg && m_tready) out_full_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_ready) begin
                        acc_reg <= 1'b0; ov_reg <= 1'b0; ob_reg <= '0; bad_reg <= 1'b0;
                        if (q_data.cmd == tlzw_pkg::CMD_PUSH) begin
                            if (scnt_reg == 0 && !fin_reg && bcnt_reg < {1'b0, width}) begin
                                buf_reg  <= {buf_reg[10:0], q_data.in_byte};
                                bcnt_reg <= bcnt_reg + 5'd8;
                                if (q_data.eos) fin_reg <= 1'b1;
                                acc_reg  <= 1'b1;
                            end
                            state_reg <= S_DEC;
                        end else if (q_data.cmd == tlzw_pkg::CMD_PULL) begin
                            state_reg <= (scnt_reg != 0) ? S_POP : S_DEC;
                        end else begin
                            if (q_data.cmd == tlzw_pkg::CMD_RESTART) begin
                                next_free_reg  <= 13'(tlzw_pkg::FIRST_FREE);
                                prev_code_reg  <= '0;
                                prev_valid_reg <= 1'b0;
                                buf_reg        <= '0;
                                bcnt_reg       <= '0;
                                scnt_reg       <= '0;
                                fin_reg        <= 1'b0;
                            end
                            state_reg <= S_RES;
                        end
                    end
                end
                S_POP: begin
                    ob_reg    <= rd_stk_reg;
                    ov_reg    <= 1'b1;
                    scnt_reg  <= scnt_reg - 13'd1;
                    state_reg <= (scnt_reg == 13'd1) ? S_DEC : S_RES;
                end
                S_DEC: begin
                    state_reg <= S_RES;
                    if (scnt_reg == 0) begin
                        if (bcnt_reg < {1'b0, width}) begin
                            if (fin_reg) begin
                                bcnt_reg <= '0; buf_reg <= '0;
                            end
                        end else begin
                            bcnt_reg <= rem;
                            buf_reg  <= buf_reg & mask;
                            code_reg <= cand;
                            walk_reg <= cand;
                            if (cand == tlzw_pkg::CLEAR_CODE) begin
                                next_free_reg  <= 13'(tlzw_pkg::FIRST_FREE);
                                prev_valid_reg <= 1'b0;
                            end else if (cand == tlzw_pkg::END_CODE) begin
                                fin_reg <= 1'b1; bcnt_reg <= '0; buf_reg <= '0;
                            end else if (cand < 12'd256 ||
                                         ({1'b0, cand} < next_free_reg)) begin
                                kwk_reg   <= 1'b0;
                                state_reg <= S_LOOK;
                            end else if (prev_valid_reg && {1'b0, cand} == next_free_reg
                                         && nf_dw < (DW + 1)'(DICT_ENTRIES)) begin
                                kwk_reg   <= 1'b1;
                                walk_reg  <= prev_code_reg;
                                state_reg <= S_LOOK;
                            end else begin
                                bad_reg <= 1'b1;
                            end
                        end
                    end
                end
                S_LOOK: begin
                    // rd_fst_reg holds the first byte of the code, rd_fst_prev_reg
                    // that of the previous code.
                    state_reg <= S_FIRST;
                end
                S_FIRST: begin
                    if (prev_valid_reg && nf_dw < (DW + 1)'(DICT_ENTRIES)) begin
                        pfx_mem[next_free_reg[DW-1:0]] <= prev_code_reg;
                        if (kwk_reg) begin
                            sfx_mem[next_free_reg[DW-1:0]] <=
                                (prev_code_reg < 12'd256) ? prev_code_reg[7:0]
                                                          : rd_fst_prev_reg;
                        end else begin
                            sfx_mem[next_free_reg[DW-1:0]] <=
                                (code_reg < 12'd256) ? code_reg[7:0] : rd_fst_reg;
                        end
                        fst_mem[next_free_reg[DW-1:0]] <=
                            (prev_code_reg < 12'd256) ? prev_code_reg[7:0] : rd_fst_prev_reg;
                        next_free_reg <= next_free_reg + 13'd1;
                    end
                    prev_code_reg  <= code_reg;
                    prev_valid_reg <= 1'b1;
                    walk_reg       <= code_reg;
                    rd_valid_reg   <= 1'b0;
                    state_reg      <= S_WALK;
                end
                S_WALK: begin
                    if (walk_reg >= tlzw_pkg::FIRST_FREE && rd_valid_reg) begin
                        stk_mem[scnt_reg[tlzw_pkg::STACK_AW-1:0]] <= rd_sfx_reg;
                        scnt_reg     <= scnt_reg + 13'd1;
                        walk_reg     <= rd_pfx_reg;
                        rd_valid_reg <= 1'b0;
                    end else if (walk_reg >= tlzw_pkg::FIRST_FREE) begin
                        rd_valid_reg <= 1'b1;
                    end else begin
                        stk_mem[scnt_reg[tlzw_pkg::STACK_AW-1:0]] <= walk_reg[7:0];
                        scnt_reg  <= scnt_reg + 13'd1;
                        state_reg <= S_RES;
                    end
                end
                S_RES: begin
                    // Waits here while the previous result is still not taken.
                    if (!out_full_reg || m_tready) begin
                        res_reg.out_byte  <= ob_reg;
                        res_reg.out_valid <= ov_reg;
                        res_reg.accepted  <= acc_reg;
                        res_reg.bad_code  <= bad_reg;
                        res_reg.done_res  <= fin_reg && scnt_reg == 0 && bcnt_reg == 0;
                        out_full_reg      <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
